// ----- design/sptc_pkg.sv -----
// ----------------------------------------------------------------------------
// sptc_pkg
// Types, constants and tables shared by the spectrum color column block.
// ----------------------------------------------------------------------------
package sptc_pkg;

   localparam int NUM_CHANNELS_DEF = 256;
   localparam int POOL_FACTOR_DEF  = 2;
   localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283;
   localparam logic [12:0] T_ONE = 13'd4096;

   localparam logic [1:0] CSR_REFERENCE = 2'd0;
   localparam logic [1:0] CSR_RANGE     = 2'd1;

   typedef struct packed {
      logic [6:0]  column;
      logic [12:0] level;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        spectrum_done;
      logic [7:0]  peak_channel;
      logic [31:0] peak_power;
   } rsp_type;

   // log2(1 + i/256) in q16, by repeated squaring; evaluated for constant table only
   function automatic logic [15:0] log_frac(input logic [7:0] i);
      logic [63:0] x;
      logic [15:0] r;
      x = 64'(256 + i) << 22;
      r = '0;
      for (int b = 15; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            r[b] = 1'b1;
            x = x >> 1;
         end
      end
      return r;
   endfunction

   function automatic logic [12:0] knot_t(input logic [2:0] k);
      logic [12:0] v;
      unique case (k)
         3'd0: v = 13'd0;
         3'd1: v = 13'd614;
         3'd2: v = 13'd1229;
         3'd3: v = 13'd2048;
         3'd4: v = 13'd2867;
         3'd5: v = 13'd3482;
         default: v = 13'd4096;
      endcase
      return v;
   endfunction

   function automatic logic [23:0] knot_rgb(input logic [2:0] k);
      logic [23:0] v;
      unique case (k)
         3'd0: v = {8'd0, 8'd0, 8'd4};
         3'd1: v = {8'd40, 8'd11, 8'd84};
         3'd2: v = {8'd101, 8'd21, 8'd110};
         3'd3: v = {8'd159, 8'd42, 8'd99};
         3'd4: v = {8'd212, 8'd72, 8'd66};
         3'd5: v = {8'd245, 8'd125, 8'd21};
         default: v = {8'd252, 8'd255, 8'd164};
      endcase
      return v;
   endfunction

endpackage

// ----- design/sptc_if.sv -----
// ----------------------------------------------------------------------------
// sptc_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface sptc_if #(parameter type payload_type = logic [31:0]);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- design/spectrum_power_to_color_column.sv -----
// ----------------------------------------------------------------------------
// spectrum_power_to_color_column
// Max-pools spectrum channels into columns, maps dB level to inferno rgb.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   power[31:0]
// rsp      out  column, level, red, green, blue, spectrum_done, peak_*
// csr      in   apb: reference_power @0, range @4
//
// a request that does not close a column is taken and the block stays ready.
// a closing request keeps req.ready low through the log of the pool value, the
// log of the reference, one multiply, a 19-step divide by the range, then three
// interpolations, each a seed state and a 21-step divide through the same
// shifter, and an output state. a zero pool or a pool at or above the
// reference skips the multiply and the range divide.
// reset is synchronous; the result register holds while rsp.ready is low, the
// next request is taken meanwhile, and the output state waits while it is full.
module spectrum_power_to_color_column #(
   parameter int NUM_CHANNELS = sptc_pkg::NUM_CHANNELS_DEF,
   parameter int POOL_FACTOR  = sptc_pkg::POOL_FACTOR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sptc_if.sink        req,
   sptc_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sptc_pkg::*;

   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PW = (POOL_FACTOR > 1) ? $clog2(POOL_FACTOR) : 1;
   localparam logic [5:0] LVL_STEPS = 6'd19;
   localparam logic [5:0] RGB_STEPS = 6'd21;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001, S_LOGM = 8'b0000_0010, S_LOGR = 8'b0000_0100,
      S_MUL  = 8'b0000_1000, S_DIV  = 8'b0001_0000, S_SEG  = 8'b0010_0000,
      S_CDIV = 8'b0100_0000, S_OUT  = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] ref_ff, ref_in;
   logic [7:0]  rng_ff, rng_in;
   logic [CW-1:0] chan_ff, chan_in;
   logic [CW-1:0] col_ff, col_in;
   logic [PW-1:0] slot_ff, slot_in;
   logic [31:0] pool_ff, pool_in, pkp_ff, pkp_in;
   logic [CW-1:0] pkc_ff, pkc_in;
   logic        last_ff, last_in;
   logic [CW-1:0] lcol_ff, lcol_in;
   logic [20:0] logm_ff, logm_in;
   logic [20:0] dlog_ff, dlog_in;
   logic [45:0] rem_ff, rem_in;
   logic [45:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [12:0] lvl_ff, lvl_in;
   logic [1:0]  comp_ff, comp_in;
   logic [23:0] rgb_ff, rgb_in;
   logic        rv_ff, rv_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] frac_rom [256];
   always_comb begin
      for (int i = 0; i < 256; i++) frac_rom[i] = log_frac(8'(i));
   end

   // shared log unit
   logic [31:0] log_arg;
   logic [4:0]  lead;
   logic [39:0] log_norm;
   logic [7:0]  fidx;
   logic [20:0] log_val;
   always_comb begin
      lead = '0;
      for (int b = 0; b < 32; b++) if (log_arg[b]) lead = 5'(b);
      // eight bits below the leading one, zero filled
      log_norm = {log_arg, 8'd0} >> lead;
      fidx = log_norm[7:0];
      log_val = {lead, frac_rom[fidx]};
   end
   assign log_arg = state_ff == S_LOGM ? pool_ff : (ref_ff == '0 ? 32'd1 : ref_ff);

   logic req_fire, csr_wr, close;
   logic [1:0] csr_idx;
   logic [7:0] rng_eff;
   assign req.ready   = (state_ff == S_IDLE);
   assign req_fire    = req.valid && req.ready;
   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx     = {1'b0, csr_paddr[2]};
   assign csr_prdata  = (csr_idx == CSR_RANGE) ? {24'd0, rng_ff} : ref_ff;
   assign rng_eff     = (rng_ff == 8'd0) ? 8'd1 : rng_ff;

   // segment select / colour operands
   logic [2:0]  seg;
   logic [12:0] k0, span, dt;
   logic [7:0]  c0, c1;
   logic [23:0] r0, r1;
   logic signed [20:0] num;
   always_comb begin
      seg = 3'd0;
      for (int k = 1; k <= 5; k++) if (lvl_ff > knot_t(3'(k))) seg = 3'(k);
      k0 = knot_t(seg);
      span = knot_t(seg + 3'd1) - k0;
      dt = lvl_ff - k0;
      r0 = knot_rgb(seg);
      r1 = knot_rgb(seg + 3'd1);
      unique case (comp_ff)
         2'd0: begin c0 = r0[23:16]; c1 = r1[23:16]; end
         2'd1: begin c0 = r0[15:8];  c1 = r1[15:8];  end
         default: begin c0 = r0[7:0]; c1 = r1[7:0]; end
      endcase
      num = $signed({13'd0, c0}) * $signed({8'd0, span})
          + $signed({8'd0, dt}) * ($signed({13'd0, c1}) - $signed({13'd0, c0}));
   end

   logic [45:0] trial;
   logic [45:0] dvs;
   logic [38:0] prod;
   assign dvs   = (state_ff == S_DIV) ? {38'd0, rng_eff} : {33'd0, span};
   assign trial = {rem_ff[44:0], quo_ff[45]};
   assign prod  = 39'(dlog_ff) * 39'(DB_PER_LOG2_Q16);

   always_comb begin
      state_in = state_ff; ref_in = ref_ff; rng_in = rng_ff;
      chan_in = chan_ff; col_in = col_ff; slot_in = slot_ff; pool_in = pool_ff;
      pkp_in = pkp_ff; pkc_in = pkc_ff; last_in = last_ff; lcol_in = lcol_ff;
      logm_in = logm_ff; dlog_in = dlog_ff; rem_in = rem_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; lvl_in = lvl_ff; comp_in = comp_ff;
      rgb_in = rgb_ff; rv_in = rv_ff; rsp_in = rsp_ff;
      close = 1'b0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      if (csr_wr) begin
         if (csr_idx == CSR_RANGE) rng_in = csr_pwdata[7:0];
         else if (csr_idx == CSR_REFERENCE) ref_in = csr_pwdata;
      end
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            if (slot_ff == '0 || req.data > pool_ff) pool_in = req.data;
            if (chan_ff == '0 || req.data > pkp_ff) begin
               pkp_in = req.data; pkc_in = chan_ff;
            end
            last_in = (32'(chan_ff) >= 32'(NUM_CHANNELS - 1));
            close = last_in || (32'(slot_ff) == 32'(POOL_FACTOR - 1));
            chan_in = last_in ? '0 : chan_ff + CW'(1);
            slot_in = close ? '0 : slot_ff + PW'(1);
            lcol_in = col_ff;
            col_in = last_in ? '0 : (close ? col_ff + CW'(1) : col_ff);
            if (close) state_in = S_LOGM;
         end
         S_LOGM: begin logm_in = log_val; state_in = S_LOGR; end
         S_LOGR: begin
            if (pool_ff == '0) begin lvl_in = '0; state_in = S_SEG; end
            else if (logm_ff >= log_val) begin lvl_in = T_ONE; state_in = S_SEG; end
            else begin dlog_in = log_val - logm_ff; state_in = S_MUL; end
         end
         S_MUL: begin
            // dividing by range << 20 equals dropping 20 bits, then dividing by range
            quo_in = {prod[38:20], 27'd0};
            rem_in = '0; cnt_in = LVL_STEPS; state_in = S_DIV;
         end
         S_DIV, S_CDIV: begin
            if (trial >= dvs) begin
               rem_in = trial - dvs; quo_in = {quo_ff[44:0], 1'b1};
            end else begin
               rem_in = trial; quo_in = {quo_ff[44:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               if (state_ff == S_DIV) begin
                  lvl_in = (quo_in >= 46'd4096) ? 13'd0 : T_ONE - quo_in[12:0];
                  state_in = S_SEG;
               end else begin
                  unique case (comp_ff)
                     2'd0: rgb_in[23:16] = quo_in[7:0];
                     2'd1: rgb_in[15:8]  = quo_in[7:0];
                     default: rgb_in[7:0] = quo_in[7:0];
                  endcase
                  if (comp_ff == 2'd2) state_in = S_OUT;
                  else begin comp_in = comp_ff + 2'd1; state_in = S_SEG; end
               end
            end
         end
         S_SEG: begin
            // colour divide: seed numerator for the current component
            quo_in = {num[20:0], 25'd0};
            rem_in = '0; cnt_in = RGB_STEPS; state_in = S_CDIV;
         end
         S_OUT: if (!rv_ff || rsp.ready) begin
            rsp_in.column = 7'(lcol_ff);
            rsp_in.level = lvl_ff;
            rsp_in.red = rgb_ff[23:16]; rsp_in.green = rgb_ff[15:8];
            rsp_in.blue = rgb_ff[7:0];
            rsp_in.spectrum_done = last_ff;
            rsp_in.peak_channel = last_ff ? 8'(pkc_ff) : 8'd0;
            rsp_in.peak_power = last_ff ? pkp_ff : 32'd0;
            rv_in = 1'b1; comp_in = 2'd0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ref_ff <= '0; rng_ff <= 8'd45;
         chan_ff <= '0; col_ff <= '0; slot_ff <= '0; pool_ff <= '0;
         pkp_ff <= '0; pkc_ff <= '0;
         rv_ff <= 1'b0; comp_ff <= 2'd0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; ref_ff <= ref_in; rng_ff <= rng_in;
         chan_ff <= chan_in; col_ff <= col_in; slot_ff <= slot_in; pool_ff <= pool_in;
         pkp_ff <= pkp_in; pkc_ff <= pkc_in; rv_ff <= rv_in;
         comp_ff <= comp_in; cnt_ff <= cnt_in;
      end
      last_ff <= last_in; lcol_ff <= lcol_in; logm_ff <= logm_in;
      dlog_ff <= dlog_in; rem_ff <= rem_in; quo_ff <= quo_in;
      lvl_ff <= lvl_in; rgb_ff <= rgb_in; rsp_ff <= rsp_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.data  = rsp_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp.ready |=> rv_ff && $stable(rsp_ff))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready)
      else $error("ready while busy");
   a_lvl: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rsp_ff.level <= T_ONE)
      else $error("level above one");
endmodule
